// ===== hw/rtl/env_assignment_line_parser_defines.svh =====
// assertion macros shared by the line parser rtl
`ifndef ENV_ASSIGNMENT_LINE_PARSER_DEFINES_SVH
`define ENV_ASSIGNMENT_LINE_PARSER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define EALP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define EALP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ealp_pkg.sv =====
// types, constants and byte classes for the assignment line parser
package ealp_pkg;

  localparam int BUF_BYTES = 4096;
  localparam int OFF_W     = $clog2(BUF_BYTES + 1);
  localparam int FIELD_W   = 12;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0b;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // scan modes
  localparam logic [2:0] M_LINE   = 3'd0;
  localparam logic [2:0] M_NAME   = 3'd1;
  localparam logic [2:0] M_NAMEWS = 3'd2;
  localparam logic [2:0] M_EQ     = 3'd3;
  localparam logic [2:0] M_VALUE  = 3'd4;
  localparam logic [2:0] M_TAIL   = 3'd5;
  localparam logic [2:0] M_SKIP   = 3'd6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] name_start;
    logic [FIELD_W-1:0] name_len;
    logic [FIELD_W-1:0] value_start;
    logic [FIELD_W-1:0] value_len;
  } out_item_t;

  function automatic logic is_blank(input logic [7:0] c);
    return c inside {CH_SPACE, CH_TAB, CH_VT, CH_FF};
  endfunction

  function automatic logic is_eol(input logic [7:0] c);
    return c inside {CH_LF, CH_CR, CH_NUL};
  endfunction

  function automatic logic is_ident(input logic [7:0] c);
    return c inside {[8'h61:8'h7a], [8'h41:8'h5a], [8'h30:8'h39], CH_UNDER};
  endfunction

endpackage

// ===== hw/rtl/env_assignment_line_parser.sv =====
// Streaming NAME = VALUE line finder, one text byte per cycle unless stalled.
// Input channel: in_valid/in_stall with in_data (data_byte, last_byte).
//   last_byte closes any open line; the next byte starts a new buffer at 0.
// Result channel: out_valid/out_stall with out_data giving name_start,
//   name_len, value_start and value_len of each valid line, sent when
//   the line ends (CR, LF, NUL, end of buffer).
// Throughput: one byte per cycle unless stalled, set by the combinational
//   scan mode update between the input register and the result register.
// Result path: the byte that ends a line passes the input register and
//   the scan logic, and its result is then held in the result register.
// A stalled result is held in the output register while one more byte
//   is taken into the input register; further bytes stall until the
//   result transfers.
// Bytes beyond the buffer size are dropped with no result until a byte
//   marked last arrives.
// Reset: synchronous active-low rst_n empties both registers and returns
//   the scanner to line start at offset 0; the block takes bytes in the
//   cycle after reset is released.
module env_assignment_line_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ealp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ealp_pkg::out_item_t out_data
);
  import ealp_pkg::*;

  `include "env_assignment_line_parser_defines.svh"

  logic            in1_valid_r;
  in_item_t        in1_data_r;
  logic            advance;
  logic            take1;

  logic [2:0]       mode_r, mode_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;
  logic [OFF_W-1:0] name_start_r, name_start_nxt;
  logic [OFF_W-1:0] name_len_r, name_len_nxt;
  logic [OFF_W-1:0] val_start_r, val_start_nxt;
  logic [OFF_W-1:0] val_len_r, val_len_nxt;
  logic             emit;

  logic             out_valid_r;
  out_item_t        out_data_r;
  out_item_t        res;

  logic [7:0]       c;
  logic             last;
  logic             buf_full;
  logic             buf_end;

  assign advance  = !out_valid_r || !out_stall;
  assign take1    = in1_valid_r && advance;
  assign in_stall = in1_valid_r && !advance;

  assign c        = in1_data_r.data_byte;
  assign last     = in1_data_r.last_byte;
  assign buf_full = (off_r == OFF_W'(BUF_BYTES));
  assign buf_end  = last || (off_r == OFF_W'(BUF_BYTES - 1));

  always_comb begin
    mode_nxt       = mode_r;
    off_nxt        = off_r;
    name_start_nxt = name_start_r;
    name_len_nxt   = name_len_r;
    val_start_nxt  = val_start_r;
    val_len_nxt    = val_len_r;
    emit           = 1'b0;

    if (buf_full) begin
      if (last) begin
        mode_nxt = M_LINE;
        off_nxt  = '0;
      end
    end else begin
      case (mode_r)
        M_LINE: begin
          if (is_blank(c) || is_eol(c)) begin
            mode_nxt = M_LINE;
          end else if (c == CH_HASH) begin
            mode_nxt = M_SKIP;
          end else if (is_ident(c)) begin
            name_start_nxt = off_r;
            name_len_nxt   = OFF_W'(1);
            mode_nxt       = M_NAME;
          end else if (c == CH_EQ) begin
            name_start_nxt = off_r;
            name_len_nxt   = '0;
            mode_nxt       = M_EQ;
            val_start_nxt  = off_r + OFF_W'(1);
            val_len_nxt    = '0;
          end else begin
            mode_nxt = M_SKIP;
          end
        end
        M_NAME, M_NAMEWS: begin
          if (mode_r == M_NAME && is_ident(c)) begin
            name_len_nxt = name_len_r + OFF_W'(1);
          end else if (is_blank(c)) begin
            mode_nxt = M_NAMEWS;
          end else if (c == CH_EQ) begin
            mode_nxt      = M_EQ;
            val_start_nxt = off_r + OFF_W'(1);
            val_len_nxt   = '0;
          end else if (is_eol(c)) begin
            mode_nxt = M_LINE;
          end else begin
            mode_nxt = M_SKIP;
          end
        end
        M_EQ: begin
          if (is_blank(c)) begin
            val_start_nxt = off_r + OFF_W'(1);
          end else if (is_eol(c)) begin
            emit     = 1'b1;
            mode_nxt = M_LINE;
          end else if (c == CH_HASH) begin
            mode_nxt = M_TAIL;
          end else begin
            val_len_nxt = OFF_W'(1);
            mode_nxt    = M_VALUE;
          end
        end
        M_VALUE: begin
          if (is_eol(c)) begin
            emit     = 1'b1;
            mode_nxt = M_LINE;
          end else if (c == CH_HASH) begin
            mode_nxt = M_TAIL;
          end else if (!is_blank(c)) begin
            // trimmed length runs to the last non-blank byte
            val_len_nxt = off_r - val_start_r + OFF_W'(1);
          end
        end
        M_TAIL: begin
          if (is_eol(c)) begin
            emit     = 1'b1;
            mode_nxt = M_LINE;
          end
        end
        default: begin
          if (is_eol(c)) begin
            mode_nxt = M_LINE;
          end
        end
      endcase

      if (buf_end) begin
        // an open assignment is closed by the end of the buffer
        if (!emit && (mode_nxt == M_EQ || mode_nxt == M_VALUE || mode_nxt == M_TAIL)) begin
          emit = 1'b1;
        end
        mode_nxt = M_LINE;
        off_nxt  = last ? '0 : OFF_W'(BUF_BYTES);
      end else begin
        off_nxt = off_r + OFF_W'(1);
      end
    end
  end

  always_comb begin
    res.name_start  = FIELD_W'(name_start_nxt);
    res.name_len    = FIELD_W'(name_len_nxt);
    res.value_start = FIELD_W'(val_start_nxt);
    res.value_len   = FIELD_W'(val_len_nxt);
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in1_data_r <= in_data;
    end
  end

  // scanner state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= M_LINE;
      off_r        <= '0;
      name_start_r <= '0;
      name_len_r   <= '0;
      val_start_r  <= '0;
      val_len_r    <= '0;
    end else if (take1) begin
      mode_r       <= mode_nxt;
      off_r        <= off_nxt;
      name_start_r <= name_start_nxt;
      name_len_r   <= name_len_nxt;
      val_start_r  <= val_start_nxt;
      val_len_r    <= val_len_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take1 && emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take1 && emit) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `EALP_ASSERT_NOW(a_off_range, 1'b1, off_r <= OFF_W'(BUF_BYTES), "offset past buffer size")
  `EALP_ASSERT_NOW(a_full_idle, buf_full, mode_r == M_LINE, "full buffer with open line")
  `EALP_ASSERT_NOW(a_name_track, mode_r == M_NAME,
    ({1'b0, name_start_r} + {1'b0, name_len_r}) == {1'b0, off_r}, "name length out of step")
  `EALP_ASSERT_NOW(a_value_order, mode_r == M_VALUE, val_start_r <= off_r,
    "value start ahead of offset")
  `EALP_ASSERT_NEXT(a_in_hold, in_stall, in1_valid_r && $stable(in1_data_r),
    "held byte lost while stalled")

endmodule
